// ===== rtl/mxt_pkg.sv =====
`default_nettype none

package mxt_pkg;

  localparam int unsigned MAX_PREFIXES = 1024;
  localparam int unsigned KEY_BITS     = 32;
  localparam int unsigned VALUE_W      = 32;

  // Root is node 0; the store holds KEY_BITS nodes for each of MAX_PREFIXES prefix paths.
  localparam int unsigned NODE_COUNT = MAX_PREFIXES * KEY_BITS + 1;
  localparam int unsigned LINK_W     = $clog2(NODE_COUNT);
  localparam int unsigned FREE_W     = $clog2(NODE_COUNT + 1);
  localparam int unsigned SUM_W      = FREE_W + 1;
  localparam int unsigned LVL_W      = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int unsigned CNT_W      = $clog2(KEY_BITS + 1);

  typedef logic [LINK_W-1:0]         link_t;
  typedef logic [1:0][LINK_W-1:0]    node_t;
  typedef logic [KEY_BITS-1:0]       key_t;

  // Result of one walk: query answer plus the point where the key leaves the trie.
  typedef struct packed {
    logic             done;
    key_t             acc;
    logic             found;
    logic [LVL_W-1:0] level;
    link_t            node;
    node_t            links;
    logic             dir_bit;
    key_t             tail;
  } walk_stat_t;

endpackage

`default_nettype wire

// ===== rtl/mxt_node_ram.sv =====
`default_nettype none

module mxt_node_ram
  import mxt_pkg::*;
(
  input  logic  clk_i,
  input  logic  we_i,
  input  link_t waddr_i,
  input  node_t wdata_i,
  input  link_t raddr_a_i,
  input  link_t raddr_b_i,
  output node_t rdata_a_o,
  output node_t rdata_b_o
);

  node_t mem_q [NODE_COUNT];
  node_t rdata_a_q;
  node_t rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== rtl/mxt_walk.sv =====
`default_nettype none

module mxt_walk
  import mxt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  key_t       key_i,
  input  node_t      root_i,
  input  node_t      rd_a_i,
  input  node_t      rd_b_i,
  output link_t      addr_a_o,
  output link_t      addr_b_o,
  output walk_stat_t stat_o
);

  key_t             key_q, key_d;
  logic [LVL_W-1:0] lvl_q, lvl_d;
  logic             active_q, active_d;
  logic             done_q, done_d;
  logic             q_stop_q, q_stop_d;
  key_t             acc_q, acc_d;
  link_t            i_cur_q, i_cur_d;
  logic             found_q, found_d;
  logic [LVL_W-1:0] level_q, level_d;
  link_t            node_q, node_d;
  node_t            links_q, links_d;
  logic             dir_q, dir_d;
  key_t             tail_q, tail_d;

  logic  cur_bit;
  logic  at_top;
  node_t q_node;
  node_t i_node;
  link_t q_alt;
  link_t q_same;
  link_t i_next;
  logic  q_hit;

  always_comb begin
    cur_bit = key_q[KEY_BITS-1];
    at_top  = (lvl_q == LVL_W'(KEY_BITS - 1));
    // Top level reads the root links; below it the registered RAM data.
    q_node  = at_top ? root_i : rd_a_i;
    i_node  = at_top ? root_i : rd_b_i;
    q_alt   = q_node[~cur_bit];
    q_same  = q_node[cur_bit];
    q_hit   = !q_stop_q && (q_alt != '0);
    i_next  = i_node[cur_bit];

    addr_a_o = (q_alt != '0) ? q_alt : q_same;
    addr_b_o = i_next;

    key_d    = key_q;
    lvl_d    = lvl_q;
    active_d = active_q;
    done_d   = 1'b0;
    q_stop_d = q_stop_q;
    acc_d    = acc_q;
    i_cur_d  = i_cur_q;
    found_d  = found_q;
    level_d  = level_q;
    node_d   = node_q;
    links_d  = links_q;
    dir_d    = dir_q;
    tail_d   = tail_q;

    if (start_i) begin
      key_d    = key_i;
      lvl_d    = LVL_W'(KEY_BITS - 1);
      active_d = 1'b1;
      q_stop_d = 1'b0;
      acc_d    = '0;
      i_cur_d  = '0;
      found_d  = 1'b0;
    end else if (active_q) begin
      key_d = key_q << 1;
      acc_d = (acc_q << 1) | KEY_BITS'(q_hit);
      // stop the query where neither child exists
      if (!q_stop_q && (q_alt == '0) && (q_same == '0)) begin
        q_stop_d = 1'b1;
      end
      if (!found_q) begin
        if (i_next == '0) begin
          found_d = 1'b1;
          level_d = lvl_q;
          node_d  = i_cur_q;
          links_d = i_node;
          dir_d   = cur_bit;
          tail_d  = key_q << 1;
        end else begin
          i_cur_d = i_next;
        end
      end
      if (lvl_q == '0) begin
        active_d = 1'b0;
        done_d   = 1'b1;
      end else begin
        lvl_d = lvl_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      done_q   <= 1'b0;
      found_q  <= 1'b0;
      q_stop_q <= 1'b0;
    end else begin
      active_q <= active_d;
      done_q   <= done_d;
      found_q  <= found_d;
      q_stop_q <= q_stop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    lvl_q   <= lvl_d;
    acc_q   <= acc_d;
    i_cur_q <= i_cur_d;
    level_q <= level_d;
    node_q  <= node_d;
    links_q <= links_d;
    dir_q   <= dir_d;
    tail_q  <= tail_d;
  end

  always_comb begin
    stat_o.done    = done_q;
    stat_o.acc     = acc_q;
    stat_o.found   = found_q;
    stat_o.level   = level_q;
    stat_o.node    = node_q;
    stat_o.links   = links_q;
    stat_o.dir_bit = dir_q;
    stat_o.tail    = tail_q;
  end

endmodule

`default_nettype wire

// ===== rtl/max_xor_subarray_trie_core.sv =====
// Per item: a trie walk, a check, then a link step and one write per fresh node when a
// new path is built (none when the key is already stored or the store is full). An
// item with the first flag first runs an extra insert pass of key zero. One item at a
// time; the next is taken once the result is registered. The walk moves one trie level
// per cycle through the node RAM, the insert one node per write. Reset (async, active
// low) empties the trie; nodes are written as allocated, no clear pass.
`default_nettype none

module max_xor_subarray_trie_core
  import mxt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic        s_axis_tuser,   // [0] first
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] max_xor
  output logic        m_axis_tuser    // [0] overflow
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_CHECK,
    S_LINK,
    S_FRESH,
    S_FINISH
  } state_e;

  state_e              state_q, state_d;
  key_t                prefix_q, prefix_d;
  key_t                best_q, best_d;
  key_t                pend_q, pend_d;
  logic [FREE_W-1:0]   next_free_q, next_free_d;
  node_t               root_q, root_d;
  logic                pass0_q, pass0_d;
  logic                of_q, of_d;
  logic [CNT_W-1:0]    remain_q, remain_d;
  key_t                tail_q, tail_d;
  logic                m_valid_q, m_valid_d;
  logic [VALUE_W-1:0]  m_data_q, m_data_d;
  logic                m_user_q, m_user_d;

  logic               walk_start;
  key_t               walk_key;
  walk_stat_t         walk_stat;
  link_t              addr_a;
  link_t              addr_b;
  node_t              rd_a;
  node_t              rd_b;
  logic               ram_we;
  link_t              ram_waddr;
  node_t              ram_wdata;

  key_t               in_val;
  logic [CNT_W-1:0]   needed;
  logic [SUM_W-1:0]   sum;
  logic               no_room;
  node_t              div_links;
  node_t              fresh_links;
  logic [FREE_W-1:0]  nf_plus;
  logic               m_free;

  mxt_walk u_walk (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (walk_start),
    .key_i    (walk_key),
    .root_i   (root_q),
    .rd_a_i   (rd_a),
    .rd_b_i   (rd_b),
    .addr_a_o (addr_a),
    .addr_b_o (addr_b),
    .stat_o   (walk_stat)
  );

  mxt_node_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (addr_a),
    .raddr_b_i (addr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  always_comb begin
    in_val  = s_axis_tdata[KEY_BITS-1:0];
    needed  = CNT_W'(walk_stat.level) + 1'b1;
    sum     = SUM_W'(next_free_q) + SUM_W'(needed);
    no_room = (sum > SUM_W'(NODE_COUNT));
    nf_plus = next_free_q + 1'b1;
    m_free  = !m_valid_q || m_axis_tready;

    div_links                    = walk_stat.links;
    div_links[walk_stat.dir_bit] = next_free_q[LINK_W-1:0];

    // fresh node links on to the next fresh node, the last one is a leaf
    fresh_links = '0;
    if (remain_q != CNT_W'(1)) begin
      fresh_links[tail_q[KEY_BITS-1]] = nf_plus[LINK_W-1:0];
    end

    walk_start = 1'b0;
    walk_key   = prefix_q;
    ram_we     = 1'b0;
    ram_waddr  = walk_stat.node;
    ram_wdata  = div_links;

    state_d     = state_q;
    prefix_d    = prefix_q;
    best_d      = best_q;
    pend_d      = pend_q;
    next_free_d = next_free_q;
    root_d      = root_q;
    pass0_d     = pass0_q;
    of_d        = of_q;
    remain_d    = remain_q;
    tail_d      = tail_q;
    m_valid_d   = m_valid_q;
    m_data_d    = m_data_q;
    m_user_d    = m_user_q;

    if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser) begin
            // new array: empty trie, then insert key zero before this element
            root_d      = '0;
            next_free_d = FREE_W'(1);
            best_d      = '0;
            prefix_d    = '0;
            pend_d      = in_val;
            pass0_d     = 1'b1;
            walk_key    = '0;
          end else begin
            prefix_d = prefix_q ^ in_val;
            pass0_d  = 1'b0;
            walk_key = prefix_q ^ in_val;
          end
          walk_start = 1'b1;
          state_d    = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_stat.done) begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!pass0_q && (walk_stat.acc > best_q)) begin
          best_d = walk_stat.acc;
        end
        if (walk_stat.found && !no_room) begin
          remain_d = needed;
          tail_d   = walk_stat.tail;
          of_d     = 1'b0;
          state_d  = S_LINK;
        end else begin
          of_d = walk_stat.found;
          if (pass0_q) begin
            pass0_d    = 1'b0;
            prefix_d   = pend_q;
            walk_key   = pend_q;
            walk_start = 1'b1;
            state_d    = S_WALK;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_LINK: begin
        // hang the first fresh node below the node where the key left the trie
        if (walk_stat.node == '0) begin
          root_d = div_links;
        end else begin
          ram_we = 1'b1;
        end
        state_d = S_FRESH;
      end
      S_FRESH: begin
        ram_we      = 1'b1;
        ram_waddr   = next_free_q[LINK_W-1:0];
        ram_wdata   = fresh_links;
        next_free_d = nf_plus;
        tail_d      = tail_q << 1;
        remain_d    = remain_q - 1'b1;
        if (remain_q == CNT_W'(1)) begin
          if (pass0_q) begin
            pass0_d    = 1'b0;
            prefix_d   = pend_q;
            walk_key   = pend_q;
            walk_start = 1'b1;
            state_d    = S_WALK;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (m_free) begin
          m_valid_d = 1'b1;
          m_data_d  = VALUE_W'(best_q);
          m_user_d  = of_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prefix_q    <= '0;
      best_q      <= '0;
      next_free_q <= FREE_W'(1);
      root_q      <= '0;
      pass0_q     <= 1'b0;
      of_q        <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      prefix_q    <= prefix_d;
      best_q      <= best_d;
      next_free_q <= next_free_d;
      root_q      <= root_d;
      pass0_q     <= pass0_d;
      of_q        <= of_d;
      m_valid_q   <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q   <= pend_d;
    remain_q <= remain_d;
    tail_q   <= tail_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= FREE_W'(NODE_COUNT))
    else $error("free node index beyond node store");

  a_fresh_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRESH) |-> (next_free_q < FREE_W'(NODE_COUNT)))
    else $error("node allocated without room");

  a_done_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.done |-> (state_q == S_WALK))
    else $error("walk finished outside of walk phase");

  a_accept_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == S_WALK))
    else $error("accepted request did not start a walk");

endmodule

`default_nettype wire

// ===== tb/max_xor_subarray_trie_core_tb.sv =====
`default_nettype none

module max_xor_subarray_trie_core_tb;
  import mxt_pkg::*;

  typedef struct packed {
    logic [31:0] max_xor;
    logic        overflow;
  } xor_result_t;

  typedef struct packed {
    logic [31:0] value;
    logic        first;
    logic        typed;
    logic [31:0] max_xor;
    logic        overflow;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 21;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // [31:0] value
  logic        s_axis_tuser;   // [0] first
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;   // [31:0] max_xor
  logic        m_axis_tuser;   // [0] overflow

  max_xor_subarray_trie_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Trie mirror: links only ever point at allocated nodes, which are zeroed on allocation.
  int unsigned trie_link [NODE_COUNT][2];
  int unsigned free_node;
  key_t        run_prefix;
  key_t        best_xor;

  xor_result_t awaited_results [$];
  stim_row_t   directed_rows [DIR_ROWS];

  int unsigned fail_count;
  int unsigned mismatch_count;
  int unsigned request_count;
  int unsigned result_count;
  int unsigned overflow_count;
  int unsigned array_count;
  int unsigned peak_nodes;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #16000000;
    $display("timeout with %0d results outstanding", awaited_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic key_t walk_best(key_t key);
    int unsigned cur;
    int unsigned alt;
    int unsigned same;
    key_t        acc;
    logic        b;
    cur = 0;
    acc = '0;
    for (int lvl = KEY_BITS - 1; lvl >= 0; lvl--) begin
      b    = key[lvl];
      alt  = trie_link[cur][b ^ 1'b1];
      same = trie_link[cur][b];
      if (alt != 0) begin
        acc[lvl] = 1'b1;
        cur      = alt;
      end else if (same != 0) begin
        cur = same;
      end else begin
        break;
      end
    end
    return acc;
  endfunction

  // Returns 1 when the path does not fit in the free nodes; nothing is written then.
  function automatic logic add_key(key_t key);
    int unsigned cur;
    int unsigned nxt;
    int unsigned needed;
    int unsigned fresh;
    int          lvl;
    logic        b;
    cur    = 0;
    needed = 0;
    lvl    = KEY_BITS - 1;
    while (lvl >= 0) begin
      b   = key[lvl];
      nxt = trie_link[cur][b];
      if (nxt == 0) begin
        needed = lvl + 1;
        break;
      end
      cur = nxt;
      lvl--;
    end
    if (needed == 0) return 1'b0;
    if (needed > NODE_COUNT - free_node) return 1'b1;
    while (lvl >= 0) begin
      b     = key[lvl];
      fresh = free_node;
      free_node++;
      trie_link[fresh][0] = 0;
      trie_link[fresh][1] = 0;
      trie_link[cur][b]   = fresh;
      cur = fresh;
      lvl--;
    end
    if (free_node > peak_nodes) peak_nodes = free_node;
    return 1'b0;
  endfunction

  function automatic xor_result_t trie_step(logic [31:0] value, logic first);
    xor_result_t r;
    key_t        q;
    if (first) begin
      trie_link[0][0] = 0;
      trie_link[0][1] = 0;
      free_node  = 1;
      run_prefix = '0;
      best_xor   = '0;
      void'(add_key('0));
    end
    run_prefix = run_prefix ^ key_t'(value);
    q = walk_best(run_prefix);
    if (q > best_xor) best_xor = q;
    r.overflow = add_key(run_prefix);
    r.max_xor  = 32'(best_xor);
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 15);
      1:       return 32'h1 << $urandom_range(0, 31);
      2:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      3:       return $urandom() << 24;
      default: return $urandom();
    endcase
  endfunction

  // Bit-reversed count: successive values spread evenly over the top trie levels.
  function automatic logic [10:0] rev11(int unsigned k);
    logic [10:0] r;
    for (int j = 0; j < 11; j++) r[j] = k[10 - j];
    return r;
  endfunction

  task automatic send_req(logic [31:0] value, logic first, logic typed, xor_result_t fixed);
    int unsigned gap;
    xor_result_t predicted;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= first;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = trie_step(value, first);
    awaited_results.push_back(typed ? fixed : predicted);
    request_count++;
    if (first) array_count++;
  endtask

  task automatic send_rand(logic [31:0] value, logic first);
    send_req(value, first, 1'b0, '0);
  endtask

  // Hold the sender until the block has delivered everything in flight.
  task automatic drain_pause();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (awaited_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result(logic [31:0] got_max, logic got_of);
    xor_result_t want;
    result_count++;
    if (got_of) overflow_count++;
    if (awaited_results.size() == 0) begin
      fail_count++;
      $display("result with nothing outstanding: max_xor=%h overflow=%b", got_max, got_of);
    end else begin
      want = awaited_results.pop_front();
      if (got_max !== want.max_xor || got_of !== want.overflow) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("mismatch at result %0d: expected max_xor=%h overflow=%b, got max_xor=%h overflow=%b",
                   result_count, want.max_xor, want.overflow, got_max, got_of);
      end
    end
  endtask

  initial begin
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 14);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        // Half the time let the result sit before stalling, so the stall hits a live result.
        if ($urandom_range(0, 1) != 0)
          while (!m_axis_tvalid) @(posedge clk_i);
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      check_result(m_axis_tdata, m_axis_tuser);
    end
  end

  initial begin
    int unsigned len;
    key_t        target;
    fail_count     = 0;
    mismatch_count = 0;
    request_count  = 0;
    result_count   = 0;
    overflow_count = 0;
    array_count    = 0;
    peak_nodes     = 1;
    quiet          = 1'b0;
    free_node      = 1;
    run_prefix     = '0;
    best_xor       = '0;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;

    directed_rows = '{
      // no array started yet: the trie is empty, so the first answer is zero
      '{32'h1234_5678, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h0000_00FF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
      '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0004, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h5555_5555, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0001_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hC000_0003, 1'b1, 1'b0, 32'h0, 1'b0},
      '{32'h0F0F_0F0F, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hF0F0_F0F0, 1'b0, 1'b0, 32'h0, 1'b0}
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_req(directed_rows[i].value, directed_rows[i].first, directed_rows[i].typed,
               '{directed_rows[i].max_xor, directed_rows[i].overflow});

    // short arrays with mixed word shapes, an occasional restart mid-array
    for (int a = 0; a < 4; a++) begin
      len = $urandom_range(1, 14);
      send_rand(rand_word(), 1'b1);
      for (int k = 1; k < len; k++)
        send_rand(rand_word(), ($urandom_range(0, 19) == 0));
    end

    drain_pause();

    // back-to-back stretch with both sides always ready
    quiet = 1'b1;
    for (int a = 0; a < 2; a++) begin
      send_rand($urandom(), 1'b1);
      for (int k = 1; k < 9; k++) send_rand(rand_word(), 1'b0);
    end
    quiet = 1'b0;

    // one long array whose prefixes spread over the top trie levels and are random
    // below: fills the node store after about 1400 words and runs on past it
    for (int k = 0; k < 1420; k++) begin
      target = {rev11(k), 21'($urandom())};
      if (k == 0) send_rand(target, 1'b1);
      else        send_rand(target ^ run_prefix, 1'b0);
    end

    // restart after the store was full
    send_rand(32'hFFFF_FFFF, 1'b1);
    for (int k = 0; k < 8; k++) send_rand(rand_word(), 1'b0);

    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (4 * KEY_BITS + 16) @(posedge clk_i);

    if (awaited_results.size() != 0) begin
      fail_count++;
      $display("%0d results never arrived", awaited_results.size());
    end
    $display("run covered %0d requests in %0d arrays, %0d results, %0d with overflow set",
             request_count, array_count, result_count, overflow_count);
    $display("trie grew to %0d of %0d nodes; %0d mismatches, %0d failures in total",
             peak_nodes, NODE_COUNT, mismatch_count, fail_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire
